// ===== rtl/spd_pkg.sv =====
// Shared types and constants for the status packet deframer.
`default_nettype none

package spd_pkg;

    // Frame constants.
    localparam logic [7:0] START_BYTE     = 8'hFF;
    localparam logic [8:0] MIN_BUFFER     = 9'd6;
    localparam logic [8:0] FRAME_OVERHEAD = 9'd4;
    localparam logic [8:0] POS_MAX        = 9'd511;

    // Byte positions of the header fields.
    localparam logic [8:0] POS_ID     = 9'd2;
    localparam logic [8:0] POS_LENGTH = 9'd3;
    localparam logic [8:0] POS_ERROR  = 9'd4;
    localparam logic [8:0] POS_PARAM0 = 9'd5;

    // Result kinds.
    localparam logic KIND_PARAM   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes.
    localparam logic [1:0] VERDICT_OK        = 2'd0;
    localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
    localparam logic [1:0] VERDICT_BAD_SUM   = 2'd2;

    // One result beat as it travels through the queue.
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic [7:0] index;
        logic [1:0] verdict;
        logic [7:0] id;
        logic [7:0] error;
        logic [7:0] total;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/status_packet_deframer.sv =====
// Top level of the status packet deframer.
`default_nettype none

// Takes one byte of a received status reply per beat, buffer_end marking the
// last byte of the buffer, and returns a parameter beat for each parameter byte
// and one verdict beat per reply (ok, malformed or bad checksum). Bytes after a
// verdict give nothing until buffer_end rearms the framer. A byte is taken every
// cycle while the result queue (QUEUE_DEPTH entries) has room; the framing
// state updates on each accepted byte, so the sustained rate is one byte per
// cycle when results are drained as fast. Results are registered in the queue.

module status_packet_deframer
    import spd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       buffer_end,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic            result_kind,
    output logic [7:0]      param_value,
    output logic [7:0]      param_index,
    output logic [1:0]      verdict,
    output logic [7:0]      servo_id,
    output logic [7:0]      error_flags,
    output logic [7:0]      param_total
);

    logic    space;
    logic    push;
    result_t push_data;
    result_t head;

    assign rx_ready = space;

    spd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (rx_valid && space),
        .rx_byte    (rx_byte),
        .buffer_end (buffer_end),
        .push       (push),
        .push_data  (push_data)
    );

    spd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .space     (space),
        .push      (push),
        .push_data (push_data),
        .pop_valid (res_valid),
        .pop_ready (res_ready),
        .pop_data  (head)
    );

    // Unpack the head beat onto the result ports.
    assign result_kind = head.kind;
    assign param_value = head.value;
    assign param_index = head.index;
    assign verdict     = head.verdict;
    assign servo_id    = head.id;
    assign error_flags = head.error;
    assign param_total = head.total;

endmodule

`default_nettype wire

// ===== rtl/spd_front.sv =====
// Front end: tracks the reply framing and classifies each accepted byte.
`default_nettype none

module spd_front
    import spd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    input  wire logic       buffer_end,
    output logic            push,
    output result_t         push_data
);

    logic [8:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] err_reg, err_next;
    logic       given_reg, given_next;
    logic       hbad_reg, hbad_next;

    logic       have_verdict;
    logic       have_param;
    logic [1:0] verdict;
    logic [8:0] pindex;
    logic [8:0] sum_pos;
    logic [7:0] total;

    assign sum_pos = {1'b0, len_reg} + FRAME_OVERHEAD - 9'd1;

    // Classify the byte against the current position and work out next state.
    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        id_next      = id_reg;
        err_next     = err_reg;
        given_next   = given_reg;
        hbad_next    = hbad_reg;
        have_verdict = 1'b0;
        have_param   = 1'b0;
        verdict      = VERDICT_OK;
        pindex       = 9'd0;
        total        = 8'd0;

        if (!given_reg)
        begin
            priority if (pos_reg < POS_ID)
            begin
                if (rx_byte != START_BYTE)
                    hbad_next = 1'b1;
            end
            else if (pos_reg == POS_ID)
            begin
                id_next  = rx_byte;
                sum_next = sum_reg + rx_byte;
            end
            else if (pos_reg == POS_LENGTH)
            begin
                len_next = rx_byte;
                sum_next = sum_reg + rx_byte;
            end
            else if (pos_reg == POS_ERROR)
            begin
                err_next = rx_byte;
                sum_next = sum_reg + rx_byte;
                if (len_reg < 8'd2)
                begin
                    have_verdict = 1'b1;
                    verdict      = VERDICT_MALFORMED;
                end
            end
            else if (pos_reg == sum_pos)
            begin
                have_verdict = 1'b1;
                if (hbad_reg || (({1'b0, len_reg} + FRAME_OVERHEAD) < MIN_BUFFER))
                    verdict = VERDICT_MALFORMED;
                else if (~sum_reg != rx_byte)
                    verdict = VERDICT_BAD_SUM;
                else
                    verdict = VERDICT_OK;
            end
            else
            begin
                sum_next   = sum_reg + rx_byte;
                have_param = 1'b1;
                pindex     = pos_reg - POS_PARAM0;
            end

            // An early end turns this beat into a malformed verdict.
            if (buffer_end && !have_verdict)
            begin
                have_verdict = 1'b1;
                have_param   = 1'b0;
                verdict      = VERDICT_MALFORMED;
            end

            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 9'd1;

            // Parameter count once the length byte has been taken.
            if ((pos_next > POS_LENGTH) && (len_next >= 8'd2))
                total = len_next - 8'd2;

            if (have_verdict)
                given_next = 1'b1;
        end

        // The final byte of the buffer rearms the framer.
        if (buffer_end)
        begin
            pos_next   = 9'd0;
            len_next   = 8'd0;
            sum_next   = 8'd0;
            id_next    = 8'd0;
            err_next   = 8'd0;
            given_next = 1'b0;
            hbad_next  = 1'b0;
        end
    end

    // Result beat handed to the queue; uses the field values after this byte.
    always_comb
    begin
        push              = accept && (have_verdict || have_param);
        push_data.kind    = have_verdict ? KIND_VERDICT : KIND_PARAM;
        push_data.value   = have_verdict ? 8'd0 : rx_byte;
        push_data.index   = have_verdict ? 8'd0 : pindex[7:0];
        push_data.verdict = have_verdict ? verdict : VERDICT_OK;
        push_data.id      = (!given_reg && pos_reg == POS_ID) ? rx_byte : id_reg;
        push_data.error   = (!given_reg && pos_reg == POS_ERROR) ? rx_byte : err_reg;
        push_data.total   = total;
    end

    // Framing state, updated on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 9'd0;
            len_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            id_reg    <= 8'd0;
            err_reg   <= 8'd0;
            given_reg <= 1'b0;
            hbad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            err_reg   <= err_next;
            given_reg <= given_next;
            hbad_reg  <= hbad_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spd_queue.sv =====
// Back end: a short result queue whose head register drives the output channel.
`default_nettype none

module spd_queue
    import spd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    output logic      space,
    input  wire logic push,
    input  result_t   push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output result_t   pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    result_t          store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign space     = (count_reg != CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = store_reg[rd_ptr_reg];

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire
